// ----- hw/rtl/lfra_pkg.sv -----
// ============================================================================
// lfra_pkg - shared constants, types and helpers
// Widths, register map, controller states and the room-count clamp.
// ============================================================================
`default_nettype none

package lfra_pkg;

    localparam int ROOMS        = 16;
    localparam int ROOM_W       = (ROOMS > 1) ? $clog2(ROOMS) : 1;
    localparam int CNT_W        = $clog2(ROOMS + 1);
    localparam int TIME_W       = 20;
    localparam int BUSY_W       = 41;
    localparam int COUNT_W      = 20;
    localparam int ROOM_FIELD_W = 4;
    localparam int CFG_W        = 5;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int REG_IDX_W    = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_ROOMS_IN_USE = REG_IDX_W'(0);
    localparam logic [CFG_W-1:0]     ROOMS_RESET      = CFG_W'(16);
    localparam logic [COUNT_W-1:0]   COUNT_MAX        = '1;

    typedef struct packed {
        logic [CFG_W-1:0] rooms_in_use;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_COUNT,
        ST_EMIT
    } state_t;

    function automatic logic [CNT_W-1:0] active_rooms(input logic [CFG_W-1:0] r);
        logic [CNT_W-1:0] n;
        if (r == '0)
            n = CNT_W'(1);
        else if (int'(r) > ROOMS)
            n = CNT_W'(ROOMS);
        else
            n = CNT_W'(r);
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lfra_ifs.sv -----
// ============================================================================
// lfra_ifs - request and result channels
// Valid/ready channels carrying one booking request and one result.
// ============================================================================
`default_nettype none

interface lfra_req_if;
    logic                       valid;
    logic                       ready;
    logic [lfra_pkg::TIME_W-1:0] start_time;
    logic [lfra_pkg::TIME_W-1:0] end_time;
    logic                       last_request;

    modport source (output valid, start_time, end_time, last_request, input ready);
    modport sink   (input valid, start_time, end_time, last_request, output ready);
endinterface

interface lfra_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [lfra_pkg::ROOM_FIELD_W-1:0] assigned_room;
    logic [lfra_pkg::ROOM_FIELD_W-1:0] most_booked_room;
    logic                             batch_done;

    modport source (output valid, assigned_room, most_booked_room, batch_done, input ready);
    modport sink   (input valid, assigned_room, most_booked_room, batch_done, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lowest_free_room_allocator_top.sv -----
// ============================================================================
// lowest_free_room_allocator_top - lowest free room allocator
// Assigns time-ordered bookings to rooms and reports the most-booked room.
// ============================================================================
// For each request taken, the busy-until memory is scanned one entry per
// cycle through its single read port over its first n entries, with n
// the clamped rooms_in_use (1 to 16); then the chosen room's busy-until
// is written and its booking count is read, updated and written back.
// Requests must arrive in nondecreasing start_time order. One request
// is in work at a time; a finished result waits in an output register while
// the next request is taken. Both memories come out of reset cleared through
// per-entry valid bits, so there is no clearing pass. Write rooms_in_use
// only while no request is outstanding.
`default_nettype none

module lowest_free_room_allocator_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    lfra_req_if.sink                           req,
    lfra_rsp_if.source                         rsp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lfra_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [lfra_pkg::PDATA_W-1:0]  pwdata,
    output logic      [lfra_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);

    lfra_pkg::cfg_t cfg;

    logic                           busy_we;
    logic [lfra_pkg::ROOM_W-1:0]    busy_waddr;
    logic [lfra_pkg::BUSY_W-1:0]    busy_wdata;
    logic                           busy_re;
    logic [lfra_pkg::ROOM_W-1:0]    busy_raddr;
    logic [lfra_pkg::BUSY_W-1:0]    busy_rdata;
    logic                           cnt_we;
    logic [lfra_pkg::ROOM_W-1:0]    cnt_waddr;
    logic [lfra_pkg::COUNT_W-1:0]   cnt_wdata;
    logic                           cnt_re;
    logic [lfra_pkg::ROOM_W-1:0]    cnt_raddr;
    logic [lfra_pkg::COUNT_W-1:0]   cnt_rdata;

    lfra_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lfra_ram #(
        .WIDTH (lfra_pkg::BUSY_W),
        .DEPTH (lfra_pkg::ROOMS)
    ) u_busy_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (busy_we),
        .waddr (busy_waddr),
        .wdata (busy_wdata),
        .re    (busy_re),
        .raddr (busy_raddr),
        .rdata (busy_rdata)
    );

    lfra_ram #(
        .WIDTH (lfra_pkg::COUNT_W),
        .DEPTH (lfra_pkg::ROOMS)
    ) u_count_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    lfra_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg        (cfg),
        .busy_we    (busy_we),
        .busy_waddr (busy_waddr),
        .busy_wdata (busy_wdata),
        .busy_re    (busy_re),
        .busy_raddr (busy_raddr),
        .busy_rdata (busy_rdata),
        .cnt_we     (cnt_we),
        .cnt_waddr  (cnt_waddr),
        .cnt_wdata  (cnt_wdata),
        .cnt_re     (cnt_re),
        .cnt_raddr  (cnt_raddr),
        .cnt_rdata  (cnt_rdata)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/lfra_ram.sv -----
// ============================================================================
// lfra_ram - single-write, single-read RAM with per-entry valid bits
// Registered read; entries never written since reset read as zero.
// ============================================================================
`default_nettype none

module lfra_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rdata_reg;
    logic             rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/lfra_cfg.sv -----
// ============================================================================
// lfra_cfg - APB configuration register
// Holds the number of rooms in use.
// ============================================================================
`default_nettype none

module lfra_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lfra_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [lfra_pkg::PDATA_W-1:0]  pwdata,
    output logic      [lfra_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    output lfra_pkg::cfg_t                     cfg
);

    logic [lfra_pkg::CFG_W-1:0]     rooms_in_use_reg;
    logic [lfra_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_en;

    assign reg_idx = paddr[lfra_pkg::PADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rooms_in_use_reg <= lfra_pkg::ROOMS_RESET;
        end
        else if (wr_en && (reg_idx == lfra_pkg::REG_ROOMS_IN_USE))
        begin
            rooms_in_use_reg <= pwdata[lfra_pkg::CFG_W-1:0];
        end
    end

    always_comb
    begin
        case (reg_idx)
            lfra_pkg::REG_ROOMS_IN_USE: prdata = lfra_pkg::PDATA_W'(rooms_in_use_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.rooms_in_use = rooms_in_use_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/lfra_ctrl.sv -----
// ============================================================================
// lfra_ctrl - allocation sequencer
// Scans busy-until entries, updates the chosen room, bumps its count,
// tracks the most-booked room and holds the result in an output register.
// ============================================================================
`default_nettype none

module lfra_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    lfra_req_if.sink                            req,
    lfra_rsp_if.source                          rsp,
    input  lfra_pkg::cfg_t                      cfg,
    output logic                                busy_we,
    output logic      [lfra_pkg::ROOM_W-1:0]    busy_waddr,
    output logic      [lfra_pkg::BUSY_W-1:0]    busy_wdata,
    output logic                                busy_re,
    output logic      [lfra_pkg::ROOM_W-1:0]    busy_raddr,
    input  wire logic [lfra_pkg::BUSY_W-1:0]    busy_rdata,
    output logic                                cnt_we,
    output logic      [lfra_pkg::ROOM_W-1:0]    cnt_waddr,
    output logic      [lfra_pkg::COUNT_W-1:0]   cnt_wdata,
    output logic                                cnt_re,
    output logic      [lfra_pkg::ROOM_W-1:0]    cnt_raddr,
    input  wire logic [lfra_pkg::COUNT_W-1:0]   cnt_rdata
);

    lfra_pkg::state_t state_reg, state_next;

    logic [lfra_pkg::TIME_W-1:0]       start_reg;
    logic [lfra_pkg::TIME_W-1:0]       dur_reg;
    logic                              last_reg;
    logic [lfra_pkg::CNT_W-1:0]        scan_cnt_reg;
    logic                              rd_pend_reg;
    logic [lfra_pkg::ROOM_W-1:0]       rd_idx_reg;
    logic                              found_reg;
    logic [lfra_pkg::ROOM_W-1:0]       free_idx_reg;
    logic [lfra_pkg::BUSY_W-1:0]       min_reg;
    logic [lfra_pkg::ROOM_W-1:0]       min_idx_reg;
    logic [lfra_pkg::ROOM_W-1:0]       room_reg;
    logic [lfra_pkg::ROOM_W-1:0]       best_idx_reg;
    logic [lfra_pkg::COUNT_W-1:0]      best_cnt_reg;
    logic                              out_valid_reg;
    logic [lfra_pkg::ROOM_FIELD_W-1:0] out_room_reg;
    logic [lfra_pkg::ROOM_FIELD_W-1:0] out_best_reg;
    logic                              out_done_reg;

    logic [lfra_pkg::CNT_W-1:0]  n_rooms;
    logic                        accept;
    logic                        scan_more;
    logic                        out_free;
    logic [lfra_pkg::ROOM_W-1:0] sel_room;
    logic [lfra_pkg::BUSY_W-1:0] base_time;
    logic [lfra_pkg::BUSY_W:0]   busy_sum;
    logic [lfra_pkg::BUSY_W-1:0] busy_new;
    logic [lfra_pkg::COUNT_W-1:0] cnt_inc;

    assign n_rooms   = lfra_pkg::active_rooms(cfg.rooms_in_use);
    assign accept    = req.valid && req.ready;
    assign scan_more = (scan_cnt_reg < n_rooms);
    assign out_free  = !out_valid_reg || rsp.ready;

    assign sel_room  = found_reg ? free_idx_reg : min_idx_reg;
    assign base_time = found_reg ? lfra_pkg::BUSY_W'(start_reg) : min_reg;
    assign busy_sum  = (lfra_pkg::BUSY_W + 1)'(base_time) + (lfra_pkg::BUSY_W + 1)'(dur_reg);
    assign busy_new  = busy_sum[lfra_pkg::BUSY_W] ? '1 : busy_sum[lfra_pkg::BUSY_W-1:0];
    assign cnt_inc   = (cnt_rdata == lfra_pkg::COUNT_MAX) ? cnt_rdata
                                                          : cnt_rdata + lfra_pkg::COUNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lfra_pkg::ST_IDLE:   if (accept) state_next = lfra_pkg::ST_SCAN;
            lfra_pkg::ST_SCAN:   if (!scan_more) state_next = lfra_pkg::ST_UPDATE;
            lfra_pkg::ST_UPDATE: state_next = lfra_pkg::ST_COUNT;
            lfra_pkg::ST_COUNT:  state_next = lfra_pkg::ST_EMIT;
            lfra_pkg::ST_EMIT:   if (out_free) state_next = lfra_pkg::ST_IDLE;
            default:             state_next = lfra_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready  = 1'b0;
        busy_re    = 1'b0;
        busy_we    = 1'b0;
        cnt_re     = 1'b0;
        cnt_we     = 1'b0;
        busy_raddr = lfra_pkg::ROOM_W'(scan_cnt_reg);
        busy_waddr = sel_room;
        busy_wdata = busy_new;
        cnt_raddr  = sel_room;
        cnt_waddr  = room_reg;
        cnt_wdata  = cnt_inc;
        case (state_reg)
            lfra_pkg::ST_IDLE:   req.ready = 1'b1;
            lfra_pkg::ST_SCAN:   busy_re   = scan_more;
            lfra_pkg::ST_UPDATE:
            begin
                busy_we = 1'b1;
                cnt_re  = 1'b1;
            end
            lfra_pkg::ST_COUNT:  cnt_we    = 1'b1;
            default:             req.ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfra_pkg::ST_IDLE;
            scan_cnt_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            best_idx_reg  <= '0;
            best_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= busy_re;
            if (accept)
            begin
                scan_cnt_reg <= '0;
                found_reg    <= 1'b0;
            end
            if (busy_re)
            begin
                scan_cnt_reg <= scan_cnt_reg + lfra_pkg::CNT_W'(1);
            end
            if (rd_pend_reg && !found_reg &&
                (busy_rdata <= lfra_pkg::BUSY_W'(start_reg)))
            begin
                found_reg <= 1'b1;
            end
            if (state_reg == lfra_pkg::ST_COUNT)
            begin
                if ((cnt_inc > best_cnt_reg) ||
                    ((cnt_inc == best_cnt_reg) && (room_reg < best_idx_reg)))
                begin
                    best_idx_reg <= room_reg;
                    best_cnt_reg <= cnt_inc;
                end
            end
            if (state_reg == lfra_pkg::ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= busy_raddr;
        if (accept)
        begin
            start_reg <= req.start_time;
            dur_reg   <= (req.end_time > req.start_time) ? req.end_time - req.start_time : '0;
            last_reg  <= req.last_request;
        end
        if (rd_pend_reg)
        begin
            if (!found_reg && (busy_rdata <= lfra_pkg::BUSY_W'(start_reg)))
            begin
                free_idx_reg <= rd_idx_reg;
            end
            if ((rd_idx_reg == '0) || (busy_rdata < min_reg))
            begin
                min_reg     <= busy_rdata;
                min_idx_reg <= rd_idx_reg;
            end
        end
        if (state_reg == lfra_pkg::ST_UPDATE)
        begin
            room_reg <= sel_room;
        end
        if (state_reg == lfra_pkg::ST_EMIT && out_free)
        begin
            out_room_reg <= lfra_pkg::ROOM_FIELD_W'(room_reg);
            out_best_reg <= lfra_pkg::ROOM_FIELD_W'(best_idx_reg);
            out_done_reg <= last_reg;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.assigned_room    = out_room_reg;
    assign rsp.most_booked_room = out_best_reg;
    assign rsp.batch_done       = out_done_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/lfra_checker.sv -----
// ============================================================================
// lfra_checker - port-level checks for the allocator
// Tracks outstanding requests and checks single-request work and result hold.
// ============================================================================
`default_nettype none

module lfra_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               req_valid,
    input wire logic                               req_ready,
    input wire logic                               rsp_valid,
    input wire logic                               rsp_ready,
    input wire logic [lfra_pkg::ROOM_FIELD_W-1:0]  assigned_room,
    input wire logic [lfra_pkg::ROOM_FIELD_W-1:0]  most_booked_room,
    input wire logic                               batch_done,
    input wire logic                               pready
);

    logic [1:0] pending_reg;
    logic       req_acc;
    logic       rsp_acc;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(req_acc) - 2'(rsp_acc);
        end
    end

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> !req_ready)
        else $error("request taken while another is in work");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |-> (pending_reg == 2'd0) || (pending_reg == 2'd1))
        else $error("too many requests outstanding");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (pending_reg != 2'd0))
        else $error("result without a request");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(assigned_room) &&
            $stable(most_booked_room) && $stable(batch_done))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind lowest_free_room_allocator_top lfra_checker u_lfra_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .assigned_room    (rsp.assigned_room),
    .most_booked_room (rsp.most_booked_room),
    .batch_done       (rsp.batch_done),
    .pready           (pready)
);

`default_nettype wire

// ----- tb/lowest_free_room_allocator_top_tb.sv -----
// ============================================================================
// lowest_free_room_allocator_top_tb - booking allocator testbench
// Sends booking requests through the request channel and compares every
// result with a cycle-free model of the room table kept in this bench, or
// with values fixed in the directed table. A short table of directed
// bookings and register writes comes first. Then random phases follow,
// each under its own room count. Random stalls fall on both channels, and
// the final phase runs without stalls and ends at the top of the time range.
// ============================================================================
`timescale 1ns / 100ps

module lowest_free_room_allocator_top_tb;

    localparam int  WATCHDOG_LIMIT = 3000;
    localparam int  NUM_PHASES     = 8;
    localparam int  PHASE_ITEMS    = 180;
    localparam int  NUM_ROWS       = 26;
    localparam int  TIME_MAX       = (1 << lfra_pkg::TIME_W) - 1;
    localparam int  PRINT_LIMIT    = 40;
    localparam logic [lfra_pkg::PADDR_W-1:0] ROOMS_ADDR = {lfra_pkg::REG_ROOMS_IN_USE, 2'b00};

    typedef struct packed {
        logic [lfra_pkg::ROOM_FIELD_W-1:0] room;
        logic [lfra_pkg::ROOM_FIELD_W-1:0] top;
        logic                              done;
    } booking_result_t;

    typedef struct packed {
        logic                              is_cfg;
        logic [lfra_pkg::CFG_W-1:0]        cfg_value;
        logic [lfra_pkg::TIME_W-1:0]       s_t;
        logic [lfra_pkg::TIME_W-1:0]       e_t;
        logic                              last;
        logic                              fixed;
        logic [lfra_pkg::ROOM_FIELD_W-1:0] room;
        logic [lfra_pkg::ROOM_FIELD_W-1:0] top;
    } plan_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [lfra_pkg::PADDR_W-1:0] paddr;
    logic [lfra_pkg::PDATA_W-1:0] pwdata;
    logic [lfra_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    lfra_req_if req_ch ();
    lfra_rsp_if rsp_ch ();

    lowest_free_room_allocator_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    logic [lfra_pkg::BUSY_W-1:0]  room_busy     [lfra_pkg::ROOMS];
    logic [lfra_pkg::COUNT_W-1:0] room_bookings [lfra_pkg::ROOMS];
    logic [lfra_pkg::CFG_W-1:0]   rooms_setting;

    booking_result_t pending_results [$];

    int  error_count;
    int  results_seen;
    int  requests_sent;
    int  delayed_bookings;
    int  config_writes;
    int  quiet_cycles;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  calm_tail;

    plan_row_t directed_plan [NUM_ROWS] = '{
        '{1'b0, 5'd0,  20'd0,  20'd10,  1'b0, 1'b1, 4'd0, 4'd0},
        '{1'b0, 5'd0,  20'd0,  20'd0,   1'b0, 1'b0, 4'd0, 4'd0},
        '{1'b0, 5'd0,  20'd0,  20'd8,   1'b0, 1'b0, 4'd0, 4'd0},
        '{1'b0, 5'd0,  20'd4,  20'd2,   1'b0, 1'b0, 4'd0, 4'd0},
        '{1'b0, 5'd0,  20'd9,  20'd12,  1'b1, 1'b0, 4'd0, 4'd0},
        '{1'b1, 5'd1,  20'd0,  20'd0,   1'b0, 1'b0, 4'd0, 4'd0},
        '{1'b0, 5'd0,  20'd20, 20'd25,  1'b0, 1'b1, 4'd0, 4'd1},
        '{1'b0, 5'd0,  20'd20, 20'd30,  1'b0, 1'b1, 4'd0, 4'd0},
        '{1'b0, 5'd0,  20'd21, 20'd21,  1'b0, 1'b1, 4'd0, 4'd0},
        '{1'b0, 5'd0,  20'd22, 20'd0,   1'b0, 1'b1, 4'd0, 4'd0},
        '{1'b1, 5'd0,  20'd0,  20'd0,   1'b0, 1'b0, 4'd0, 4'd0},
        '{1'b0, 5'd0,  20'd40, 20'd50,  1'b1, 1'b1, 4'd0, 4'd0},
        '{1'b0, 5'd0,  20'd41, 20'd45,  1'b0, 1'b1, 4'd0, 4'd0},
        '{1'b1, 5'd31, 20'd0,  20'd0,   1'b0, 1'b0, 4'd0, 4'd0},
        '{1'b0, 5'd0,  20'd41, 20'd43,  1'b0, 1'b0, 4'd0, 4'd0},
        '{1'b0, 5'd0,  20'd41, 20'd100, 1'b0, 1'b0, 4'd0, 4'd0},
        '{1'b0, 5'd0,  20'd41, 20'd60,  1'b0, 1'b0, 4'd0, 4'd0},
        '{1'b1, 5'd2,  20'd0,  20'd0,   1'b0, 1'b0, 4'd0, 4'd0},
        '{1'b0, 5'd0,  20'd42, 20'd50,  1'b0, 1'b0, 4'd0, 4'd0},
        '{1'b0, 5'd0,  20'd42, 20'd52,  1'b0, 1'b0, 4'd0, 4'd0},
        '{1'b0, 5'd0,  20'd42, 20'd52,  1'b0, 1'b0, 4'd0, 4'd0},
        '{1'b0, 5'd0,  20'd43, 20'd46,  1'b0, 1'b0, 4'd0, 4'd0},
        '{1'b0, 5'd0,  20'd43, 20'd44,  1'b0, 1'b0, 4'd0, 4'd0},
        '{1'b0, 5'd0,  20'd10, 20'd20,  1'b1, 1'b0, 4'd0, 4'd0},
        '{1'b1, 5'd16, 20'd0,  20'd0,   1'b0, 1'b0, 4'd0, 4'd0},
        '{1'b0, 5'd0,  20'd10, 20'd20,  1'b0, 1'b0, 4'd0, 4'd0}
    };

    logic [lfra_pkg::CFG_W-1:0] phase_rooms [NUM_PHASES] = '{
        5'd16, 5'd4, 5'd1, 5'd31, 5'd0, 5'd9, 5'd17, 5'd16
    };

    function automatic int usable_rooms(input logic [lfra_pkg::CFG_W-1:0] setting);
        int n;
        n = int'(setting);
        if (n < 1)
            n = 1;
        if (n > lfra_pkg::ROOMS)
            n = lfra_pkg::ROOMS;
        return n;
    endfunction

    function automatic booking_result_t allocate_booking(
        input logic [lfra_pkg::TIME_W-1:0] s_t,
        input logic [lfra_pkg::TIME_W-1:0] e_t,
        input logic                        last
    );
        logic [lfra_pkg::BUSY_W-1:0] dur;
        logic [lfra_pkg::BUSY_W-1:0] base;
        logic [lfra_pkg::BUSY_W:0]   wide;
        logic                        free_found;
        int                          n;
        int                          pick;
        int                          top;
        booking_result_t             r;
        dur = (e_t > s_t) ? lfra_pkg::BUSY_W'(e_t - s_t) : '0;
        n = usable_rooms(rooms_setting);
        free_found = 1'b0;
        pick = 0;
        for (int i = 0; i < n; i++)
        begin
            if (!free_found && room_busy[i] <= lfra_pkg::BUSY_W'(s_t))
            begin
                pick = i;
                free_found = 1'b1;
            end
        end
        if (free_found)
        begin
            base = lfra_pkg::BUSY_W'(s_t);
        end
        else
        begin
            pick = 0;
            for (int i = 1; i < n; i++)
            begin
                if (room_busy[i] < room_busy[pick])
                    pick = i;
            end
            base = room_busy[pick];
            delayed_bookings++;
        end
        wide = {1'b0, base} + {1'b0, dur};
        room_busy[pick] = wide[lfra_pkg::BUSY_W] ? {lfra_pkg::BUSY_W{1'b1}}
                                                 : wide[lfra_pkg::BUSY_W-1:0];
        if (room_bookings[pick] != {lfra_pkg::COUNT_W{1'b1}})
            room_bookings[pick] = room_bookings[pick] + 1'b1;
        top = 0;
        for (int i = 1; i < lfra_pkg::ROOMS; i++)
        begin
            if (room_bookings[i] > room_bookings[top])
                top = i;
        end
        r.room = lfra_pkg::ROOM_FIELD_W'(pick);
        r.top  = lfra_pkg::ROOM_FIELD_W'(top);
        r.done = last;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("[%0t] result %0d: %s got %0d, want %0d", $time, results_seen, what,
                     got, want);
    endtask

    task automatic offer_request(input logic [lfra_pkg::TIME_W-1:0]       s_t,
                                 input logic [lfra_pkg::TIME_W-1:0]       e_t,
                                 input logic                              last,
                                 input logic                              fixed,
                                 input logic [lfra_pkg::ROOM_FIELD_W-1:0] f_room,
                                 input logic [lfra_pkg::ROOM_FIELD_W-1:0] f_top);
        booking_result_t predicted;
        req_ch.valid        <= 1'b1;
        req_ch.start_time   <= s_t;
        req_ch.end_time     <= e_t;
        req_ch.last_request <= last;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = allocate_booking(s_t, e_t, last);
        if (fixed)
            predicted = '{room: f_room, top: f_top, done: last};
        pending_results.push_back(predicted);
        requests_sent++;
    endtask

    task automatic pause_sender();
        int gap;
        gap = 0;
        if (!calm_tail && $urandom_range(0, 99) < send_idle_pct)
            gap = $urandom_range(1, 14);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle_block();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_rooms(input logic [lfra_pkg::CFG_W-1:0] value);
        logic [lfra_pkg::PDATA_W-1:0] word;
        logic [lfra_pkg::PDATA_W-1:0] readback;
        word = $urandom;
        word[lfra_pkg::CFG_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ROOMS_ADDR;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rooms_setting = value;
        config_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback != lfra_pkg::PDATA_W'(value))
            report_mismatch("rooms_in_use readback", int'(readback), int'(value));
    endtask

    // receiver: stall in bursts of random length
    initial
    begin
        int hold;
        hold = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!calm_tail && $urandom_range(0, 99) < recv_idle_pct)
            begin
                hold = $urandom_range(0, 13);
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        booking_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no request outstanding, assigned_room",
                                int'(rsp_ch.assigned_room), 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.assigned_room !== want.room)
                    report_mismatch("assigned_room", int'(rsp_ch.assigned_room),
                                    int'(want.room));
                if (rsp_ch.most_booked_room !== want.top)
                    report_mismatch("most_booked_room", int'(rsp_ch.most_booked_room),
                                    int'(want.top));
                if (rsp_ch.batch_done !== want.done)
                    report_mismatch("batch_done", int'(rsp_ch.batch_done), int'(want.done));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || psel || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no request or result moved for %0d cycles", quiet_cycles);
                $display("lowest_free_room_allocator_top verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int                          cursor;
        int                          n;
        int                          kind;
        int                          dur;
        int                          back;
        int                          floor_t;
        logic [lfra_pkg::TIME_W-1:0] s_t;
        logic [lfra_pkg::TIME_W-1:0] e_t;
        logic                        last;

        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.start_time   <= '0;
        req_ch.end_time     <= '0;
        req_ch.last_request <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        error_count      = 0;
        results_seen     = 0;
        requests_sent    = 0;
        delayed_bookings = 0;
        config_writes    = 0;
        quiet_cycles     = 0;
        calm_tail        = 1'b0;
        send_idle_pct    = 30;
        recv_idle_pct    = 30;
        rooms_setting    = lfra_pkg::ROOMS_RESET;
        for (int i = 0; i < lfra_pkg::ROOMS; i++)
        begin
            room_busy[i]     = '0;
            room_bookings[i] = '0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[r])
        begin
            if (directed_plan[r].is_cfg)
            begin
                settle_block();
                program_rooms(directed_plan[r].cfg_value);
            end
            else
            begin
                offer_request(directed_plan[r].s_t, directed_plan[r].e_t,
                              directed_plan[r].last, directed_plan[r].fixed,
                              directed_plan[r].room, directed_plan[r].top);
                pause_sender();
            end
        end

        cursor = 100;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle_block();
            program_rooms(phase_rooms[p]);
            calm_tail = (p == NUM_PHASES - 1);
            send_idle_pct = calm_tail ? 0 : $urandom_range(0, 50);
            recv_idle_pct = calm_tail ? 0 : $urandom_range(0, 50);
            n = usable_rooms(phase_rooms[p]);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                kind = $urandom_range(0, 99);
                last = ($urandom_range(0, 11) == 0);
                if (calm_tail && k >= PHASE_ITEMS - 8)
                begin
                    // climb to the top of the time range
                    floor_t = TIME_MAX - (PHASE_ITEMS - 1 - k) * 4000;
                    cursor = (cursor > floor_t) ? cursor : floor_t;
                    s_t = lfra_pkg::TIME_W'(cursor);
                    e_t = {lfra_pkg::TIME_W{1'b1}};
                end
                else if (kind < 85)
                begin
                    cursor = cursor + $urandom_range(0, 1300);
                    if (cursor > TIME_MAX)
                        cursor = TIME_MAX;
                    dur = (kind < 10) ? $urandom_range(0, 40) : $urandom_range(0, n * 1200);
                    s_t = lfra_pkg::TIME_W'(cursor);
                    e_t = lfra_pkg::TIME_W'((cursor + dur > TIME_MAX) ? TIME_MAX
                                                                      : cursor + dur);
                end
                else if (kind < 92)
                begin
                    s_t = lfra_pkg::TIME_W'(cursor);
                    e_t = lfra_pkg::TIME_W'($urandom_range(0, cursor));
                end
                else
                begin
                    // step back below the cursor
                    back = (cursor > 0) ? $urandom_range(1, (cursor < 3000) ? cursor : 3000) : 0;
                    dur = $urandom_range(0, 2000);
                    s_t = lfra_pkg::TIME_W'(cursor - back);
                    e_t = lfra_pkg::TIME_W'((cursor - back + dur > TIME_MAX) ? TIME_MAX
                                                                             : cursor - back + dur);
                end
                offer_request(s_t, e_t, last, 1'b0, '0, '0);
                pause_sender();
            end
        end

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d bookings, %0d delayed behind busy rooms, under %0d room-count writes.",
                 requests_sent, delayed_bookings, config_writes);
        $display("Compared %0d results; %0d mismatches.", results_seen, error_count);
        if (error_count == 0)
            $display("lowest_free_room_allocator_top verification clean");
        else
            $display("lowest_free_room_allocator_top verification failed");
        $finish;
    end

endmodule
